[rtl/kbf_pkg.sv]
package kbf_pkg;

    localparam int KEY_W      = 64;
    localparam int COEF_W     = 31;
    localparam int KLEN_W     = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_HASHES = 3;
    localparam int HIDX_W     = 2;

    typedef enum logic [1:0] {
        REQ_WINDOW_RESET = 2'd0,
        REQ_PUSH         = 2'd1,
        REQ_INSERT       = 2'd2,
        REQ_QUERY        = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KMER_LENGTH    = 3'd0,
        CFG_REVERSE_ENABLE = 3'd1,
        CFG_HASH_MULT_0    = 3'd2,
        CFG_HASH_ADD_0     = 3'd3,
        CFG_HASH_MULT_1    = 3'd4,
        CFG_HASH_ADD_1     = 3'd5,
        CFG_HASH_MULT_2    = 3'd6,
        CFG_HASH_ADD_2     = 3'd7
    } cfg_reg_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    localparam logic [35:0]       HASH_MOD          = 36'd68719476735;
    localparam logic [KLEN_W-1:0] KMER_LENGTH_RESET = 6'd16;
    localparam logic [KEY_W-1:0]  MIRROR_RESET      = 64'h0000_0000_FFFF_FFFF;

    localparam logic [COEF_W-1:0] MULT_RESET_0 = 31'd1804289383;
    localparam logic [COEF_W-1:0] ADD_RESET_0  = 31'd846930886;
    localparam logic [COEF_W-1:0] MULT_RESET_1 = 31'd1681692777;
    localparam logic [COEF_W-1:0] ADD_RESET_1  = 31'd1714636915;
    localparam logic [COEF_W-1:0] MULT_RESET_2 = 31'd1957747793;
    localparam logic [COEF_W-1:0] ADD_RESET_2  = 31'd424238335;

    typedef struct packed {
        logic [COEF_W-1:0] mult;
        logic [COEF_W-1:0] add;
    } coef_t;

    typedef struct packed {
        op_t              op;
        logic             two_keys;
        logic [KEY_W-1:0] key_a;
        logic [KEY_W-1:0] key_b;
        logic [KEY_W-1:0] fwd;
        logic [KEY_W-1:0] rev;
    } item_t;

    typedef struct packed {
        logic wr;
        logic last;
    } tag_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } back_ctrl_t;

endpackage

[rtl/kbf_front.sv]
module kbf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [1:0]                    req_type,
    input  logic [1:0]                    symbol,
    input  logic [kbf_pkg::KEY_W-1:0]     key,
    input  logic [kbf_pkg::KLEN_W-1:0]    kmer_length,
    input  logic                          reverse_enable,
    input  kbf_pkg::back_ctrl_t           back_ctrl,
    output logic                          busy,
    output logic                          head_valid,
    output kbf_pkg::item_t                head
);

    logic [kbf_pkg::KEY_W-1:0]  window_key_reg;
    logic [kbf_pkg::KEY_W-1:0]  window_key_next;
    logic [kbf_pkg::KEY_W-1:0]  mirror_key_reg;
    logic [kbf_pkg::KEY_W-1:0]  mirror_key_next;
    kbf_pkg::item_t             q_reg [2];
    logic                       wr_ptr_reg;
    logic                       rd_ptr_reg;
    logic [1:0]                 count_reg;
    logic [1:0]                 count_next;

    logic [kbf_pkg::KLEN_W-1:0] eff_len;
    logic [kbf_pkg::KEY_W-1:0]  mask;
    logic [5:0]                 rev_sh;
    logic [1:0]                 comp;
    logic [kbf_pkg::KEY_W-1:0]  push_fwd;
    logic [kbf_pkg::KEY_W-1:0]  push_rev;
    logic                       accept;
    kbf_pkg::item_t             new_item;

    // effective window length and mask
    always_comb
    begin
        eff_len = kmer_length;
        if (kmer_length == 6'd0)
        begin
            eff_len = 6'd1;
        end
        else if (kmer_length > 6'd32)
        begin
            eff_len = 6'd32;
        end
        for (int i = 0; i < 32; i++)
        begin
            mask[2*i +: 2] = {2{(6'(i) < eff_len)}};
        end
    end

    assign rev_sh   = {eff_len[4:0] - 5'd1, 1'b0};
    assign comp     = 2'd3 - symbol;
    assign push_fwd = ((window_key_reg << 2) | {62'd0, symbol}) & mask;
    assign push_rev = (mirror_key_reg >> 2) + ({62'd0, comp} << rev_sh);

    assign busy       = (count_reg == 2'd2) || back_ctrl.clearing;
    assign accept     = start && !busy;
    assign head_valid = (count_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    // classify the request and roll the window
    always_comb
    begin
        window_key_next   = window_key_reg;
        mirror_key_next   = mirror_key_reg;
        new_item.op       = kbf_pkg::OP_NONE;
        new_item.two_keys = 1'b0;
        new_item.key_a    = key;
        new_item.key_b    = push_rev;
        case (kbf_pkg::req_t'(req_type))
            kbf_pkg::REQ_WINDOW_RESET:
            begin
                window_key_next = '0;
                mirror_key_next = mask;
            end
            kbf_pkg::REQ_PUSH:
            begin
                window_key_next   = push_fwd;
                mirror_key_next   = push_rev;
                new_item.op       = kbf_pkg::OP_INSERT;
                new_item.two_keys = reverse_enable;
                new_item.key_a    = push_fwd;
            end
            kbf_pkg::REQ_INSERT:
            begin
                new_item.op = kbf_pkg::OP_INSERT;
            end
            kbf_pkg::REQ_QUERY:
            begin
                new_item.op = kbf_pkg::OP_QUERY;
            end
            default:
            begin
                new_item.op = kbf_pkg::OP_NONE;
            end
        endcase
        new_item.fwd = window_key_next;
        new_item.rev = mirror_key_next;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept && !back_ctrl.pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!accept && back_ctrl.pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_key_reg <= '0;
            mirror_key_reg <= kbf_pkg::MIRROR_RESET;
            wr_ptr_reg     <= 1'b0;
            rd_ptr_reg     <= 1'b0;
            count_reg      <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                window_key_reg <= window_key_next;
                mirror_key_reg <= mirror_key_next;
                wr_ptr_reg     <= !wr_ptr_reg;
            end
            if (back_ctrl.pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

[rtl/kbf_hash.sv]
module kbf_hash #(
    parameter int IDX_W = 20
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  kbf_pkg::tag_t             in_tag,
    input  logic [kbf_pkg::KEY_W-1:0] in_key,
    input  kbf_pkg::coef_t            in_coef,
    output logic                      out_valid,
    output kbf_pkg::tag_t             out_tag,
    output logic [IDX_W-1:0]          out_idx
);

    logic                         v1_reg;
    logic                         v2_reg;
    logic                         v3_reg;
    logic                         v4_reg;
    kbf_pkg::tag_t                tag1_reg;
    kbf_pkg::tag_t                tag2_reg;
    kbf_pkg::tag_t                tag3_reg;
    kbf_pkg::tag_t                tag4_reg;
    logic [62:0]                  lo1_reg;
    logic [31:0]                  hi1_reg;
    logic [kbf_pkg::COEF_W-1:0]   add1_reg;
    logic [63:0]                  h2_reg;
    logic [36:0]                  s3_reg;
    logic [IDX_W-1:0]             idx4_reg;

    logic [36:0]                  fold;
    logic [36:0]                  red;

    // end-around fold for mod 2^36-1
    assign fold = {36'd0, s3_reg[36]} + {1'b0, s3_reg[35:0]};
    assign red  = (fold >= {1'b0, kbf_pkg::HASH_MOD}) ? fold - {1'b0, kbf_pkg::HASH_MOD} : fold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= in_tag;
        lo1_reg  <= {32'd0, in_coef.mult} * {31'd0, in_key[31:0]};
        hi1_reg  <= {1'b0, in_coef.mult} * in_key[63:32];
        add1_reg <= in_coef.add;

        tag2_reg <= tag1_reg;
        h2_reg   <= {1'b0, lo1_reg} + {hi1_reg, 32'd0} + {33'd0, add1_reg};

        tag3_reg <= tag2_reg;
        s3_reg   <= {9'd0, h2_reg[63:36]} + {1'b0, h2_reg[35:0]};

        tag4_reg <= tag3_reg;
        idx4_reg <= red[IDX_W-1:0];
    end

    assign out_valid = v4_reg;
    assign out_tag   = tag4_reg;
    assign out_idx   = idx4_reg;

endmodule

[rtl/kbf_back.sv]
module kbf_back #(
    parameter int BLOOM_BITS = 1048576,
    parameter int NUM_HASHES = 3
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  kbf_pkg::item_t               head,
    input  kbf_pkg::coef_t [2:0]         coefs,
    output kbf_pkg::back_ctrl_t          back_ctrl,
    output logic                         done,
    output logic                         hit,
    output logic [kbf_pkg::KEY_W-1:0]    forward_key,
    output logic [kbf_pkg::KEY_W-1:0]    reverse_key
);

    localparam int IDX_W  = $clog2(BLOOM_BITS);
    localparam int COL_W  = (IDX_W <= 6) ? IDX_W - 1 : 6;
    localparam int ROW_AW = IDX_W - COL_W;
    localparam int ROW_W  = 1 << COL_W;
    localparam int ROWS   = 1 << ROW_AW;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ISSUE = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [ROW_AW-1:0]              clr_row_reg;
    logic [ROW_AW-1:0]              clr_row_next;
    logic [kbf_pkg::HIDX_W-1:0]     hidx_reg;
    logic [kbf_pkg::HIDX_W-1:0]     hidx_next;
    logic                           ksel_reg;
    logic                           ksel_next;
    logic                           hit_acc_reg;
    logic                           hit_acc_next;
    logic                           done_reg;
    logic                           done_next;
    logic                           hit_reg;
    logic                           hit_next;
    logic [kbf_pkg::KEY_W-1:0]      fwd_reg;
    logic [kbf_pkg::KEY_W-1:0]      rev_reg;
    logic                           mv_reg;
    kbf_pkg::tag_t                  mtag_reg;
    logic [COL_W-1:0]               mcol_reg;
    logic [ROW_W-1:0]               rd_row_reg;
    logic [ROW_W-1:0]               mem [ROWS];

    logic                           pop;
    logic                           issue_valid;
    logic                           last_hash;
    kbf_pkg::tag_t                  issue_tag;
    logic [kbf_pkg::KEY_W-1:0]      issue_key;
    logic                           h_valid;
    kbf_pkg::tag_t                  h_tag;
    logic [IDX_W-1:0]               h_idx;
    logic [ROW_AW-1:0]              h_row;
    logic [COL_W-1:0]               h_col;
    logic                           bit_val;

    assign issue_valid    = (state_reg == ST_ISSUE);
    assign last_hash      = (hidx_reg == kbf_pkg::HIDX_W'(NUM_HASHES - 1));
    assign issue_key      = ksel_reg ? head.key_b : head.key_a;
    assign issue_tag.wr   = (head.op == kbf_pkg::OP_INSERT);
    assign issue_tag.last = last_hash && !(head.two_keys && !ksel_reg);

    kbf_hash #(
        .IDX_W (IDX_W)
    ) u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue_valid),
        .in_tag    (issue_tag),
        .in_key    (issue_key),
        .in_coef   (coefs[hidx_reg]),
        .out_valid (h_valid),
        .out_tag   (h_tag),
        .out_idx   (h_idx)
    );

    assign h_row   = h_idx[IDX_W-1:COL_W];
    assign h_col   = h_idx[COL_W-1:0];
    assign bit_val = rd_row_reg[mcol_reg];

    // single-port bit store: clear sweep, bit set or row read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
        begin
            mem[clr_row_reg] <= '0;
        end
        else if (h_valid && h_tag.wr)
        begin
            mem[h_row][h_col] <= 1'b1;
        end
        else if (h_valid)
        begin
            rd_row_reg <= mem[h_row];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_row_next = clr_row_reg;
        hidx_next    = hidx_reg;
        ksel_next    = ksel_reg;
        hit_acc_next = hit_acc_reg;
        done_next    = 1'b0;
        hit_next     = 1'b0;
        pop          = 1'b0;
        if (mv_reg && !mtag_reg.wr)
        begin
            hit_acc_next = hit_acc_reg & bit_val;
        end
        case (state_reg)
            ST_CLEAR:
            begin
                clr_row_next = clr_row_reg + 1'b1;
                if (&clr_row_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    if (head.op == kbf_pkg::OP_NONE)
                    begin
                        done_next = 1'b1;
                        pop       = 1'b1;
                    end
                    else
                    begin
                        state_next   = ST_ISSUE;
                        hidx_next    = '0;
                        ksel_next    = 1'b0;
                        hit_acc_next = 1'b1;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (last_hash)
                begin
                    if (head.two_keys && !ksel_reg)
                    begin
                        ksel_next = 1'b1;
                        hidx_next = '0;
                    end
                    else
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    hidx_next = hidx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (mv_reg && mtag_reg.last)
                begin
                    done_next  = 1'b1;
                    hit_next   = !mtag_reg.wr && hit_acc_reg && bit_val;
                    pop        = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_row_reg <= '0;
            hidx_reg    <= '0;
            ksel_reg    <= 1'b0;
            hit_acc_reg <= 1'b1;
            done_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            mv_reg      <= 1'b0;
            mtag_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_row_reg <= clr_row_next;
            hidx_reg    <= hidx_next;
            ksel_reg    <= ksel_next;
            hit_acc_reg <= hit_acc_next;
            done_reg    <= done_next;
            hit_reg     <= hit_next;
            mv_reg      <= h_valid;
            mtag_reg    <= h_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        mcol_reg <= h_col;
        if (done_next)
        begin
            fwd_reg <= head.fwd;
            rev_reg <= head.rev;
        end
    end

    assign back_ctrl.pop      = pop;
    assign back_ctrl.clearing = (state_reg == ST_CLEAR);
    assign done               = done_reg;
    assign hit                = hit_reg;
    assign forward_key        = fwd_reg;
    assign reverse_key        = rev_reg;

`ifndef ASSERT_OFF
    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue pop without a queued item");
    a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !h_valid)
        else $error("bit store access during clear sweep");
    a_hit_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> done_reg)
        else $error("hit raised outside a result transfer");
    a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (mv_reg && mtag_reg.last) |-> (state_reg == ST_DRAIN))
        else $error("last job returned outside drain");
`endif

endmodule

[rtl/kmer_bloom_filter.sv]
// k-mer bloom filter
// input: an item is taken at a rising edge with start high and busy low.
//   req_type 0 resets the k-mer window, 1 pushes symbol and inserts the
//   forward key (and the reverse complement key when reverse_enable is set),
//   2 inserts key, 3 queries key.
// output: one result per item, shown for one cycle with done high; hit is 1
//   only for a query whose hashed bits are all set. forward_key and
//   reverse_key give the window keys after the item. there is no stall on
//   the result side.
// config: cfg_we writes cfg_data into register cfg_index at the edge.
// flow: a window reset is answered from the back end idle state with no
//   hashing; other items make N = NUM_HASHES bit-store accesses per item
//   (twice that for a push with reverse_enable), one per hash, through the
//   4-stage hash pipeline and one single-port memory. items run one at a
//   time in the back end; a two-entry queue lets the front take one more.
// reset: window keys and config go to defaults and the bit store is swept
//   to zero, one 64-bit row a cycle (BLOOM_BITS/64 rows, 16384 by
//   default) while busy stays high.
module kmer_bloom_filter #(
    parameter int BLOOM_BITS = 1048576,
    parameter int NUM_HASHES = 3
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [1:0]                       req_type,
    input  logic [1:0]                       symbol,
    input  logic [kbf_pkg::KEY_W-1:0]        key,
    output logic                             done,
    output logic                             hit,
    output logic [kbf_pkg::KEY_W-1:0]        forward_key,
    output logic [kbf_pkg::KEY_W-1:0]        reverse_key,
    input  logic                             cfg_we,
    input  logic [kbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kbf_pkg::COEF_W-1:0]       cfg_data
);

    logic [kbf_pkg::KLEN_W-1:0]  kmer_length_reg;
    logic                        reverse_enable_reg;
    kbf_pkg::coef_t [2:0]        coef_reg;

    kbf_pkg::back_ctrl_t         back_ctrl;
    logic                        head_valid;
    kbf_pkg::item_t              head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg    <= kbf_pkg::KMER_LENGTH_RESET;
            reverse_enable_reg <= 1'b0;
            coef_reg[0].mult   <= kbf_pkg::MULT_RESET_0;
            coef_reg[0].add    <= kbf_pkg::ADD_RESET_0;
            coef_reg[1].mult   <= kbf_pkg::MULT_RESET_1;
            coef_reg[1].add    <= kbf_pkg::ADD_RESET_1;
            coef_reg[2].mult   <= kbf_pkg::MULT_RESET_2;
            coef_reg[2].add    <= kbf_pkg::ADD_RESET_2;
        end
        else if (cfg_we)
        begin
            case (kbf_pkg::cfg_reg_t'(cfg_index))
                kbf_pkg::CFG_KMER_LENGTH:    kmer_length_reg    <= cfg_data[kbf_pkg::KLEN_W-1:0];
                kbf_pkg::CFG_REVERSE_ENABLE: reverse_enable_reg <= cfg_data[0];
                kbf_pkg::CFG_HASH_MULT_0:    coef_reg[0].mult   <= cfg_data;
                kbf_pkg::CFG_HASH_ADD_0:     coef_reg[0].add    <= cfg_data;
                kbf_pkg::CFG_HASH_MULT_1:    coef_reg[1].mult   <= cfg_data;
                kbf_pkg::CFG_HASH_ADD_1:     coef_reg[1].add    <= cfg_data;
                kbf_pkg::CFG_HASH_MULT_2:    coef_reg[2].mult   <= cfg_data;
                kbf_pkg::CFG_HASH_ADD_2:     coef_reg[2].add    <= cfg_data;
                default:
                begin
                    kmer_length_reg <= kmer_length_reg;
                end
            endcase
        end
    end

    kbf_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .req_type       (req_type),
        .symbol         (symbol),
        .key            (key),
        .kmer_length    (kmer_length_reg),
        .reverse_enable (reverse_enable_reg),
        .back_ctrl      (back_ctrl),
        .busy           (busy),
        .head_valid     (head_valid),
        .head           (head)
    );

    kbf_back #(
        .BLOOM_BITS (BLOOM_BITS),
        .NUM_HASHES (NUM_HASHES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .coefs       (coef_reg),
        .back_ctrl   (back_ctrl),
        .done        (done),
        .hit         (hit),
        .forward_key (forward_key),
        .reverse_key (reverse_key)
    );

endmodule
